FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/crcfc_pkg.sv
// types, codes and crc step functions for the crc8 / crc16 frame checker
// no dependencies
package crcfc_pkg;

  localparam logic [7:0]  NARROW_POLY = 8'h8c;
  localparam logic [15:0] WIDE_POLY   = 16'h8408;

  // output queue depth and the most beats one input beat can cause
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_BURST   = 3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    REG_USE_WIDE    = 2'd0,
    REG_GEN_MODE    = 2'd1,
    REG_NARROW_SEED = 2'd2,
    REG_WIDE_SEED   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        check_byte;
    logic [1:0]  status;
    logic [15:0] check;
  } result_beat_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ NARROW_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // reflected crc-16 (0x1021), one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ WIDE_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/crc8_crc16_frame_check.sv
// crc8 / crc16 frame checker top level
// depends on crcfc_pkg and assert_macros.svh
//
// Frame bytes arrive one beat at a time with frame_end on the final byte. The
// block keeps a reflected crc-8 (maxim) and a reflected crc-16 (0x1021) side by
// side; use_wide_check picks which one is reported. In verify mode the frame's
// last one (crc-8) or two (crc-16) bytes are the checksum tail, low byte first,
// and one status beat comes out at frame end: ok, too short (two bytes or fewer)
// or mismatch. In generate mode every byte is echoed and the checksum bytes are
// appended after the last byte, low byte first; a crc-8 frame of one data byte
// gets no check byte. Seeds are loaded at the first byte of every frame.
// The crc step is a combinational bitwise loop between the state registers, so
// one byte is taken per clock unless in_stall. Result beats go into a four-entry
// output queue; the input is stalled while more than one beat is queued, so
// single-result traffic runs at one byte per clock unless out_stall; a
// generate-mode frame end (up to three result beats) stalls the input. The
// configuration must be written only while idle; the block does not enforce it.
module crc8_crc16_frame_check
  import crcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        is_check_byte,
  output logic [1:0]  frame_status,
  output logic [15:0] computed_check
);

  `include "assert_macros.svh"

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BST_W = $clog2(MAX_BURST + 1);

  // configuration registers
  logic        use_wide_check;
  logic        generate_mode;
  logic [7:0]  narrow_seed;
  logic [15:0] wide_seed;

  // running frame state
  logic [7:0]  narrow_running;
  logic [15:0] wide_running;
  logic [15:0] wide_one_back;
  logic [7:0]  previous_byte;
  logic [1:0]  byte_count;

  // output queue
  result_beat_t     queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic in_acc;
  logic out_acc;
  logic verify_inner_acc;

  // state as seen by this beat: seeds replace it at a frame start
  logic [7:0]  base_narrow;
  logic [15:0] base_wide;
  logic [15:0] base_one_back;
  logic [7:0]  base_prev;
  logic [1:0]  base_count;

  logic [7:0]  narrow_running_next;
  logic [15:0] wide_running_next;
  logic [1:0]  byte_count_next;
  logic [15:0] run;
  logic        wide_ok;
  logic        narrow_ok;

  result_beat_t     burst [MAX_BURST];
  logic [BST_W-1:0] burst_len;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      use_wide_check <= 1'b1;
      generate_mode  <= 1'b0;
      narrow_seed    <= 8'hff;
      wide_seed      <= 16'hffff;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_USE_WIDE:    use_wide_check <= cfg_data[0];
        REG_GEN_MODE:    generate_mode  <= cfg_data[0];
        REG_NARROW_SEED: narrow_seed    <= cfg_data[7:0];
        REG_WIDE_SEED:   wide_seed      <= cfg_data;
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes: stall only on the registered queue fill, never on out_stall
  // ---------------------------------------------------------------------------
  assign in_stall = (count > CNT_W'(QUEUE_DEPTH - MAX_BURST));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // verify-mode byte that is not the frame's last one
  assign verify_inner_acc = in_acc && !generate_mode && !frame_end;

  // ---------------------------------------------------------------------------
  // one crc step per accepted byte
  // ---------------------------------------------------------------------------
  always_comb begin
    if (byte_count == 2'd0) begin
      base_narrow   = narrow_seed;
      base_wide     = wide_seed;
      base_one_back = wide_seed;
      base_prev     = 8'h00;
      base_count    = 2'd0;
    end else begin
      base_narrow   = narrow_running;
      base_wide     = wide_running;
      base_one_back = wide_one_back;
      base_prev     = previous_byte;
      base_count    = byte_count;
    end

    narrow_running_next = crc8_step(base_narrow, data_byte);
    wide_running_next   = crc16_step(base_wide, data_byte);
    byte_count_next     = (base_count == 2'd3) ? 2'd3 : base_count + 2'd1;
    run = use_wide_check ? wide_running_next : {8'h00, narrow_running_next};

    // tail compare: crc16 two bytes back, crc8 one byte back
    wide_ok   = (base_one_back[7:0] == base_prev) && (base_one_back[15:8] == data_byte);
    narrow_ok = (base_narrow == data_byte);
  end

  // result beats caused by this byte
  always_comb begin
    for (int k = 0; k < MAX_BURST; k++) begin
      burst[k] = '{data: 8'h00, last: 1'b0, check_byte: 1'b0,
                   status: STATUS_OK, check: 16'h0000};
    end
    burst_len = '0;

    if (generate_mode) begin
      burst[0] = '{data: data_byte,
                   last: frame_end && !use_wide_check && (byte_count_next < 2'd2),
                   check_byte: 1'b0, status: STATUS_OK, check: run};
      burst[1] = '{data: run[7:0], last: !use_wide_check, check_byte: 1'b1,
                   status: STATUS_OK, check: run};
      burst[2] = '{data: run[15:8], last: 1'b1, check_byte: 1'b1,
                   status: STATUS_OK, check: run};
      if (!frame_end) begin
        burst_len = BST_W'(1);
      end else if (use_wide_check) begin
        burst_len = BST_W'(3);
      end else if (byte_count_next >= 2'd2) begin
        burst_len = BST_W'(2);
      end else begin
        burst_len = BST_W'(1);
      end
    end else if (frame_end) begin
      burst_len = BST_W'(1);
      if (byte_count_next <= 2'd2) begin
        burst[0] = '{data: 8'h00, last: 1'b1, check_byte: 1'b0,
                     status: STATUS_SHORT, check: 16'h0000};
      end else if (use_wide_check) begin
        burst[0] = '{data: 8'h00, last: 1'b1, check_byte: 1'b0,
                     status: wide_ok ? STATUS_OK : STATUS_MISMATCH,
                     check: base_one_back};
      end else begin
        burst[0] = '{data: 8'h00, last: 1'b1, check_byte: 1'b0,
                     status: narrow_ok ? STATUS_OK : STATUS_MISMATCH,
                     check: {8'h00, base_narrow}};
      end
    end
  end

  // frame state registers; frame end clears the count so the next byte reseeds
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 2'd0;
    end else if (in_acc) begin
      byte_count <= frame_end ? 2'd0 : byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      narrow_running <= narrow_running_next;
      wide_running   <= wide_running_next;
      wide_one_back  <= base_wide;
      previous_byte  <= data_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  always_comb begin
    count_next = count;
    if (in_acc) begin
      count_next = count_next + CNT_W'(burst_len);
    end
    if (out_acc) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + PTR_W'(burst_len);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BURST; k++) begin
      if (in_acc && (BST_W'(k) < burst_len)) begin
        queue[wr_ptr + PTR_W'(k)] <= burst[k];
      end
    end
  end

  assign out_valid      = (count != '0);
  assign out_byte       = queue[rd_ptr].data;
  assign out_last       = queue[rd_ptr].last;
  assign is_check_byte  = queue[rd_ptr].check_byte;
  assign frame_status   = queue[rd_ptr].status;
  assign computed_check = queue[rd_ptr].check;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(a_queue_bound, count <= CNT_W'(QUEUE_DEPTH), "output queue overfilled")
  `ASSERT_NEXT(a_gen_echo, in_acc && generate_mode, out_valid, "generate beat produced no echo")
  `ASSERT_NEXT(a_verify_end, in_acc && !generate_mode && frame_end, out_valid, "no status beat")
  `ASSERT_NEXT(a_verify_inner, verify_inner_acc && !out_acc, $stable(count), "inner byte beat")

endmodule
